>>> sv/frd_pkg.sv
// ----------------------------------------------------------------------------
// frd_pkg: shared types, constants and CRC helpers
// Parse phases, control states and the bitwise CRC-11 / CRC-24 steps used by
// the FlexRay record deframer.
// ----------------------------------------------------------------------------
package frd_pkg;

  localparam int MAX_PAYLOAD_BYTES_DEF = 254;

  localparam logic [10:0] CRC11_INIT = 11'h01A;
  localparam logic [10:0] CRC11_POLY = 11'h385;
  localparam logic [23:0] CRC24_INIT = 24'hFEDCBA;
  localparam logic [23:0] CRC24_POLY = 24'h5D6DCB;

  localparam logic [15:0] BODY_OVERHEAD = 16'd9;
  localparam logic [2:0]  REPLAY_LEN    = 3'd5;

  typedef enum logic [2:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SRC,
    PH_HDR,
    PH_PAY,
    PH_CRC
  } phase_t;

  typedef enum logic [1:0] {
    ST_FEED,
    ST_REPLAY,
    ST_RD,
    ST_OUT
  } state_t;

  // Shift the low nbits of data (msb first) through the CRC-11 register.
  function automatic logic [10:0] crc11_bits(input logic [10:0] crc,
                                             input logic [7:0] data,
                                             input logic [3:0] nbits);
    logic [10:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (i < int'(nbits)) begin
        fb = data[i] ^ c[10];
        c  = {c[9:0], 1'b0};
        if (fb) c = c ^ CRC11_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [23:0] crc24_byte(input logic [23:0] crc,
                                             input logic [7:0] data);
    logic [23:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = data[i] ^ c[23];
      c  = {c[22:0], 1'b0};
      if (fb) c = c ^ CRC24_POLY;
    end
    return c;
  endfunction

endpackage

>>> sv/flexray_record_deframer.sv
// ----------------------------------------------------------------------------
// flexray_record_deframer: FlexRay record parser with CRC-11/CRC-24 check
// Parses the record byte stream, checks both CRCs and emits payload words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one record byte per beat (in_valid / in_stall); the block stalls
//           the input while it replays or bursts.
//   cfg_* : bus base write, always ready; write only while idle.
//   out_* : one payload word per beat, held in an output register that the
//           receiver may stall for any time.
// Throughput: one byte per cycle while parsing. A header word-count
// mismatch replays five buffered bytes, one per cycle, with the input stalled.
// After the last CRC byte a good frame is sent as ceil(payload bytes/4)
// words, or one empty word; each word passes through a payload RAM read
// (ST_RD) and then an output register load (ST_OUT).
// Bad frames produce nothing.
// Reset (rst_n low, synchronous) returns the parser to waiting for a length
// low byte and drops any held output word; the payload RAM is not cleared.
// While out_stall is high the current word holds and the burst waits.
// ----------------------------------------------------------------------------
module flexray_record_deframer #(
  parameter int MAX_PAYLOAD_BYTES = frd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_bus_base,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_fr_id,
  output logic [8:0]  out_bus_number,
  output logic [5:0]  out_cyc_cnt,
  output logic [7:0]  out_payload_bytes,
  output logic [5:0]  out_word_index,
  output logic [31:0] out_pay_word,
  output logic        out_last
);

  import frd_pkg::*;

  localparam int WORDS = (MAX_PAYLOAD_BYTES + 3) / 4;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int KW    = $clog2(WORDS + 1);
  localparam int PW    = ($clog2(MAX_PAYLOAD_BYTES + 1) > 3) ?
                         $clog2(MAX_PAYLOAD_BYTES + 1) : 3;
  localparam logic [15:0] MAX_BODY = 16'(MAX_PAYLOAD_BYTES + 9);

  state_t      st_r, st_nxt;
  phase_t      ph_r, ph_nxt;
  logic [7:0]  recent_r [6];
  logic [7:0]  recent_nxt [6];
  logic [7:0]  rep_r [5];
  logic [2:0]  rep_cnt_r, rep_cnt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [39:0] hdr_r, hdr_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [23:0] crc24_r, crc24_nxt;
  logic [23:0] rx_r, rx_nxt;
  logic [10:0] crc11_r, crc11_nxt;
  logic [7:0]  bus_off_r;
  logic [KW-1:0] kw_r;

  logic        fire, rescan, finish, good, mem_we, load, last_word;
  logic [7:0]  b;
  logic [15:0] len_t;
  logic [10:0] hcrc;
  logic [7:0]  pb;
  logic [8:0]  nw;
  logic [31:0] rdata, word_m;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != ST_FEED);
  assign fire      = (st_r == ST_FEED && in_valid) || (st_r == ST_REPLAY);
  assign b         = (st_r == ST_REPLAY) ? rep_r[0] : in_data_byte;

  // byte parser
  always_comb begin
    ph_nxt    = ph_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    hdr_nxt   = hdr_r;
    src_nxt   = src_r;
    crc24_nxt = crc24_r;
    rx_nxt    = rx_r;
    crc11_nxt = crc11_r;
    rescan    = 1'b0;
    finish    = 1'b0;
    mem_we    = 1'b0;
    len_t     = {b, len_r[7:0]};
    for (int i = 0; i < 5; i++) recent_nxt[i] = recent_r[i+1];
    recent_nxt[5] = b;
    unique case (ph_r)
      PH_LEN_LO: begin
        len_nxt = {8'h00, b};
        ph_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        if (len_t < BODY_OVERHEAD || len_t > MAX_BODY) begin
          len_nxt = {8'h00, b};
        end else begin
          len_nxt = len_t;
          ph_nxt  = PH_SRC;
        end
      end
      PH_SRC: begin
        src_nxt   = b;
        crc24_nxt = CRC24_INIT;
        crc11_nxt = CRC11_INIT;
        hdr_nxt   = '0;
        rx_nxt    = '0;
        pos_nxt   = '0;
        ph_nxt    = PH_HDR;
      end
      PH_HDR: begin
        hdr_nxt   = {hdr_r[31:0], b};
        crc24_nxt = crc24_byte(crc24_r, b);
        pos_nxt   = pos_r + PW'(1);
        if (pos_r == PW'(0)) crc11_nxt = crc11_bits(crc11_r, b, 4'd5);
        if (pos_r == PW'(1)) crc11_nxt = crc11_bits(crc11_r, b, 4'd8);
        if (pos_r == PW'(2)) crc11_nxt = crc11_bits(crc11_r, {1'b0, b[7:1]}, 4'd7);
        if (pos_r == PW'(2) && {8'h00, b[7:1], 1'b0} != len_r - BODY_OVERHEAD) begin
          // word count disagrees: drop the length low byte and rescan
          ph_nxt  = PH_LEN_LO;
          pos_nxt = '0;
          rescan  = 1'b1;
        end else if (pos_r == PW'(4)) begin
          pos_nxt = '0;
          ph_nxt  = (len_r == BODY_OVERHEAD) ? PH_CRC : PH_PAY;
        end
      end
      PH_PAY: begin
        mem_we    = 1'b1;
        crc24_nxt = crc24_byte(crc24_r, b);
        pos_nxt   = pos_r + PW'(1);
        if (16'(pos_r) + 16'd1 >= len_r - BODY_OVERHEAD) begin
          pos_nxt = '0;
          ph_nxt  = PH_CRC;
        end
      end
      PH_CRC: begin
        rx_nxt  = {rx_r[15:0], b};
        pos_nxt = pos_r + PW'(1);
        if (pos_r == PW'(2)) begin
          finish  = 1'b1;
          pos_nxt = '0;
          ph_nxt  = PH_LEN_LO;
        end
      end
      default: begin
        ph_nxt  = PH_LEN_LO;
        pos_nxt = '0;
      end
    endcase
  end

  assign hcrc = {hdr_r[16], hdr_r[15:8], hdr_r[7:6]};
  assign good = (crc11_r == hcrc) && (crc24_r == rx_nxt);
  assign pb   = 8'(len_r - BODY_OVERHEAD);
  assign nw   = (pb == 8'd0) ? 9'd1 : 9'(({1'b0, pb} + 9'd3) >> 2);
  assign last_word = (9'(kw_r) + 9'd1 == nw);
  assign load = (st_r == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (10'(kw_r) * 10'd4 + 10'(j) < 10'(pb)) word_m[31-8*j -: 8] = rdata[31-8*j -: 8];
      else word_m[31-8*j -: 8] = 8'h00;
    end
  end

  // control next state
  always_comb begin
    st_nxt      = st_r;
    rep_cnt_nxt = rep_cnt_r;
    unique case (st_r) inside
      ST_FEED, ST_REPLAY: begin
        if (st_r == ST_REPLAY) rep_cnt_nxt = rep_cnt_r - 3'd1;
        if (fire && rescan) begin
          st_nxt      = ST_REPLAY;
          rep_cnt_nxt = REPLAY_LEN;
        end else if (fire && finish && good) begin
          st_nxt = ST_RD;
        end else if (st_r == ST_REPLAY && rep_cnt_r == 3'd1) begin
          st_nxt = ST_FEED;
        end
      end
      ST_RD:  st_nxt = ST_OUT;
      ST_OUT: if (load) st_nxt = last_word ? ST_FEED : ST_RD;
      default: st_nxt = ST_FEED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_FEED;
      ph_r      <= PH_LEN_LO;
      rep_cnt_r <= '0;
      pos_r     <= '0;
      len_r     <= '0;
      hdr_r     <= '0;
      src_r     <= '0;
      crc24_r   <= CRC24_INIT;
      rx_r      <= '0;
      crc11_r   <= CRC11_INIT;
      bus_off_r <= '0;
      kw_r      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 6; i++) recent_r[i] <= 8'h00;
    end else begin
      st_r      <= st_nxt;
      rep_cnt_r <= rep_cnt_nxt;
      if (cfg_valid && cfg_ready) bus_off_r <= cfg_bus_base;
      if (fire) begin
        ph_r    <= ph_nxt;
        pos_r   <= pos_nxt;
        len_r   <= len_nxt;
        hdr_r   <= hdr_nxt;
        src_r   <= src_nxt;
        crc24_r <= crc24_nxt;
        rx_r    <= rx_nxt;
        crc11_r <= crc11_nxt;
        for (int i = 0; i < 6; i++) recent_r[i] <= recent_nxt[i];
      end
      if (load) kw_r <= last_word ? '0 : kw_r + KW'(1);
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // replay buffer: capture the five bytes after the dropped low byte, then shift
  always_ff @(posedge clk) begin
    if (fire && rescan) begin
      for (int i = 0; i < 5; i++) rep_r[i] <= recent_nxt[i+1];
    end else if (st_r == ST_REPLAY) begin
      for (int i = 0; i < 4; i++) rep_r[i] <= rep_r[i+1];
      rep_r[4] <= 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_fr_id         <= {hdr_r[34:32], hdr_r[31:24]};
      out_bus_number    <= 9'(src_r) + 9'(bus_off_r);
      out_cyc_cnt       <= hdr_r[5:0];
      out_payload_bytes <= pb;
      out_word_index    <= 6'(kw_r);
      out_pay_word      <= word_m;
      out_last          <= last_word;
    end
  end

  frd_payload_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (fire && mem_we),
    .waddr (AW'(pos_r >> 2)),
    .wlane (pos_r[1:0]),
    .wdata (b),
    .raddr (AW'(kw_r)),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  a_no_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD || st_r == ST_OUT) |-> !fire)
    else $error("payload write during output burst");
  a_replay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_REPLAY) |-> (rep_cnt_r != 3'd0))
    else $error("replay with empty count");
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |-> (st_r == ST_RD || st_r == ST_OUT))
    else $error("burst ended before last beat");
  a_no_rescan_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_REPLAY) |-> !(rescan || finish))
    else $error("rescan or frame end during replay");
`endif

endmodule

>>> sv/frd_payload_ram.sv
// ----------------------------------------------------------------------------
// frd_payload_ram: payload byte store
// Four byte-lane memories, written one byte at a time and read one full
// 32-bit word at a time with a registered read port.
// ----------------------------------------------------------------------------
module frd_payload_ram #(
  parameter int WORDS = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [1:0]    wlane,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [7:0] lane0_mem [WORDS];
  logic [7:0] lane1_mem [WORDS];
  logic [7:0] lane2_mem [WORDS];
  logic [7:0] lane3_mem [WORDS];

  always_ff @(posedge clk) begin
    if (we && wlane == 2'd0) lane0_mem[waddr] <= wdata;
    if (we && wlane == 2'd1) lane1_mem[waddr] <= wdata;
    if (we && wlane == 2'd2) lane2_mem[waddr] <= wdata;
    if (we && wlane == 2'd3) lane3_mem[waddr] <= wdata;
  end

  // earliest byte lands in the top lane of the word
  always_ff @(posedge clk) begin
    rdata <= {lane0_mem[raddr], lane1_mem[raddr], lane2_mem[raddr], lane3_mem[raddr]};
  end

endmodule

>>> dv/flexray_record_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flexray_record_deframer_test: self-checking bench for the record deframer
// Builds FlexRay records (length, source, header, payload, CRC-24) with good
// and broken CRCs, bad lengths, word-count mismatches and line noise, feeds
// them byte by byte under random idling and a long output hold, and checks
// every payload word against a cycle-free model of the parser.
// ----------------------------------------------------------------------------
module flexray_record_deframer_test;
  import frd_pkg::*;

  localparam int MAXPL = 254;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum int {K_GOOD, K_BAD_HCRC, K_BAD_PCRC, K_BAD_LEN, K_MISMATCH, K_NOISE} rec_kind_t;
  typedef enum int {P_ZERO, P_ONES, P_INC, P_RAND} pat_t;

  typedef struct {
    logic [10:0] fr_id;
    logic [8:0]  bus_number;
    logic [5:0]  cyc_cnt;
    logic [7:0]  payload_bytes;
    logic [5:0]  word_index;
    logic [31:0] pay_word;
    logic        last;
  } frame_word_t;

  typedef struct {
    rec_kind_t   kind;
    logic [10:0] id;
    logic [4:0]  ind;
    logic [5:0]  cyc;
    logic [7:0]  src;
    int          pb;
    pat_t        pat;
    int          n_words;   // -1: not read off by hand
    bit          w0_known;
    logic [31:0] w0;
  } rec_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_bus_base = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_fr_id;
  logic [8:0]  out_bus_number;
  logic [5:0]  out_cyc_cnt;
  logic [7:0]  out_payload_bytes;
  logic [5:0]  out_word_index;
  logic [31:0] out_pay_word;
  logic        out_last;

  flexray_record_deframer dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser shadow state
  phase_t      sh_phase;
  int          sh_pos;
  logic [15:0] sh_len;
  logic [39:0] sh_hdr;
  logic [7:0]  sh_src;
  logic [23:0] sh_crc;
  logic [23:0] sh_rx_crc;
  logic [7:0]  sh_recent [6];
  logic [7:0]  sh_store [MAXPL];
  logic [7:0]  sh_offset;

  frame_word_t expected_words[$];
  int          n_pushed = 0;
  logic [31:0] last_word0;
  int          errors = 0;
  int          cycles = 0;
  int          n_sent = 0;
  bit          quiet = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  logic [7:0]  rec_bytes[$];
  rec_row_t    rows[$];

  function automatic logic [23:0] calc_crc24(logic [23:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = b[i] ^ c[23];
      c = {c[22:0], 1'b0};
      if (fb) c = c ^ 24'h5D6DCB;
    end
    return c;
  endfunction

  function automatic logic [10:0] calc_crc11(logic [19:0] w);
    logic [10:0] c;
    logic fb;
    c = 11'h01A;
    for (int i = 19; i >= 0; i--) begin
      fb = w[i] ^ c[10];
      c = {c[9:0], 1'b0};
      if (fb) c = c ^ 11'h385;
    end
    return c;
  endfunction

  function automatic void emit_frame();
    logic [7:0]  h0, h2, h3, h4;
    logic [10:0] id, hcrc;
    logic [19:0] dw;
    int          pb, nw;
    frame_word_t fw;
    h0 = sh_hdr[39:32];
    h2 = sh_hdr[23:16];
    h3 = sh_hdr[15:8];
    h4 = sh_hdr[7:0];
    id = {h0[2:0], sh_hdr[31:24]};
    hcrc = {h2[0], h3, h4[7:6]};
    dw = {h0[4:3], id, h2[7:1]};
    pb = int'(sh_len) - 9;
    if (calc_crc11(dw) != hcrc || sh_crc != sh_rx_crc || pb > MAXPL) return;
    nw = (pb != 0) ? (pb + 3) / 4 : 1;
    for (int k = 0; k < nw; k++) begin
      fw.pay_word = '0;
      for (int j = 0; j < 4; j++)
        fw.pay_word = {fw.pay_word[23:0], (k*4 + j < pb) ? sh_store[k*4 + j] : 8'h00};
      fw.fr_id = id;
      fw.bus_number = {1'b0, sh_src} + {1'b0, sh_offset};
      fw.cyc_cnt = h4[5:0];
      fw.payload_bytes = pb[7:0];
      fw.word_index = k[5:0];
      fw.last = (k + 1 == nw);
      if (k == 0) last_word0 = fw.pay_word;
      expected_words = {expected_words, fw};
      n_pushed++;
    end
  endfunction

  // Returns 1 when the header word count disagrees with the body length.
  function automatic bit parse_byte(logic [7:0] b);
    for (int i = 0; i < 5; i++) sh_recent[i] = sh_recent[i+1];
    sh_recent[5] = b;
    case (sh_phase)
      PH_LEN_LO: begin
        sh_len = {8'h00, b};
        sh_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sh_len = sh_len | {b, 8'h00};
        if (sh_len < 9 || sh_len > 9 + MAXPL) sh_len = {8'h00, b};
        else sh_phase = PH_SRC;
      end
      PH_SRC: begin
        sh_src = b;
        sh_crc = 24'hFEDCBA;
        sh_hdr = '0;
        sh_rx_crc = '0;
        sh_pos = 0;
        sh_phase = PH_HDR;
      end
      PH_HDR: begin
        sh_hdr = {sh_hdr[31:0], b};
        sh_crc = calc_crc24(sh_crc, b);
        sh_pos++;
        if (sh_pos == 3 && int'(b[7:1]) * 2 != int'(sh_len) - 9) begin
          sh_phase = PH_LEN_LO;
          sh_pos = 0;
          return 1'b1;
        end
        if (sh_pos >= 5) begin
          sh_pos = 0;
          sh_phase = (sh_len == 9) ? PH_CRC : PH_PAY;
        end
      end
      PH_PAY: begin
        if (sh_pos < MAXPL) sh_store[sh_pos] = b;
        sh_crc = calc_crc24(sh_crc, b);
        sh_pos++;
        if (sh_pos >= int'(sh_len) - 9) begin
          sh_pos = 0;
          sh_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        sh_rx_crc = {sh_rx_crc[15:0], b};
        sh_pos++;
        if (sh_pos >= 3) begin
          emit_frame();
          sh_pos = 0;
          sh_phase = PH_LEN_LO;
        end
      end
      default: begin
        sh_phase = PH_LEN_LO;
        sh_pos = 0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [7:0] pend[$];
    logic [7:0] x;
    pend = {b};
    while (pend.size() > 0) begin
      x = pend.pop_front();
      if (parse_byte(x)) begin
        pend = {};
        // rescan the five bytes after the dropped length low byte
        for (int i = 1; i < 6; i++) pend = {pend, sh_recent[i]};
      end
    end
  endfunction

  function automatic void build_record(rec_row_t r);
    logic [7:0]  pay[$];
    logic [7:0]  hdr[5];
    logic [6:0]  words;
    logic [10:0] hcrc;
    logic [23:0] crc;
    logic [15:0] blen;
    if (r.kind == K_NOISE) begin
      repeat ($urandom_range(1, 6)) rec_bytes = {rec_bytes, 8'($urandom_range(255))};
      return;
    end
    for (int i = 0; i < r.pb; i++)
      case (r.pat)
        P_ZERO: pay = {pay, 8'h00};
        P_ONES: pay = {pay, 8'hFF};
        P_INC:  pay = {pay, i[7:0]};
        default: pay = {pay, 8'($urandom_range(255))};
      endcase
    words = 7'(r.pb / 2);
    if (r.kind == K_MISMATCH) words = words + 7'd1 + 7'($urandom_range(5));
    hcrc = calc_crc11({r.ind[1:0], r.id, words});
    if (r.kind == K_BAD_HCRC) hcrc = hcrc ^ (11'd1 << $urandom_range(10));
    hdr[0] = {r.ind, r.id[10:8]};
    hdr[1] = r.id[7:0];
    hdr[2] = {words, hcrc[10]};
    hdr[3] = hcrc[9:2];
    hdr[4] = {hcrc[1:0], r.cyc};
    blen = 16'(r.pb + 9);
    if (r.kind == K_BAD_LEN) blen = $urandom_range(1) ? 16'hFFFF : 16'(8'($urandom_range(8)));
    rec_bytes = {rec_bytes, blen[7:0]};
    rec_bytes = {rec_bytes, blen[15:8]};
    rec_bytes = {rec_bytes, r.src};
    crc = 24'hFEDCBA;
    for (int i = 0; i < 5; i++) begin
      rec_bytes = {rec_bytes, hdr[i]};
      crc = calc_crc24(crc, hdr[i]);
    end
    foreach (pay[i]) begin
      rec_bytes = {rec_bytes, pay[i]};
      crc = calc_crc24(crc, pay[i]);
    end
    if (r.kind == K_BAD_PCRC) crc = crc ^ (24'd1 << $urandom_range(23));
    rec_bytes = {rec_bytes, crc[23:16]};
    rec_bytes = {rec_bytes, crc[15:8]};
    rec_bytes = {rec_bytes, crc[7:0]};
  endfunction

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_byte(b);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_record(input rec_row_t r);
    rec_bytes = {};
    build_record(r);
    foreach (rec_bytes[i]) send_byte(rec_bytes[i]);
  endtask

  task automatic write_offset(input logic [7:0] v);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (16) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_bus_base <= v;
    do @(posedge clk); while (!cfg_ready);
    sh_offset = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic rec_row_t random_row();
    rec_row_t r;
    int roll;
    roll = $urandom_range(99);
    r.kind = (roll < 75) ? K_GOOD : (roll < 80) ? K_BAD_HCRC : (roll < 85) ? K_BAD_PCRC :
             (roll < 90) ? K_MISMATCH : (roll < 95) ? K_BAD_LEN : K_NOISE;
    r.id = 11'($urandom_range(2047));
    r.ind = 5'($urandom_range(31));
    r.cyc = 6'($urandom_range(63));
    r.src = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(255));
    r.pb = 2 * int'($urandom_range(0, 8));
    r.pat = P_RAND;
    r.n_words = -1;
    r.w0_known = 0;
    r.w0 = '0;
    return r;
  endfunction

  function automatic void add_row(rec_kind_t k, int id, int ind, int cyc, int src, int pb,
                                  pat_t p, int nw, bit known, logic [31:0] w0);
    rec_row_t r;
    r = '{k, 11'(id), 5'(ind), 6'(cyc), 8'(src), pb, p, nw, known, w0};
    rows = {rows, r};
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    frame_word_t fw;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, got id %0h data %0h", $time, out_fr_id,
                 out_pay_word);
        errors++;
      end else begin
        fw = expected_words.pop_front();
        check_field("id", fw.fr_id, out_fr_id);
        check_field("bus_number", fw.bus_number, out_bus_number);
        check_field("cycle", fw.cyc_cnt, out_cyc_cnt);
        check_field("payload_bytes", fw.payload_bytes, out_payload_bytes);
        check_field("word_index", fw.word_index, out_word_index);
        check_field("word", fw.pay_word, out_pay_word);
        check_field("last", fw.last, out_last);
      end
    end
  end

  // receiver: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && !quiet && ($urandom_range(99) < 15);
    end
  end

  initial begin
    int n_prior, n;
    sh_phase = PH_LEN_LO;
    sh_pos = 0;
    sh_len = '0;
    sh_hdr = '0;
    sh_src = '0;
    sh_crc = 24'hFEDCBA;
    sh_rx_crc = '0;
    sh_offset = '0;
    foreach (sh_recent[i]) sh_recent[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed records; desyncing cases go near the end, where word counts are unchecked
    add_row(K_GOOD, 0, 0, 0, 0, 0, P_ZERO, 1, 1, 32'h0);
    add_row(K_GOOD, 2047, 31, 63, 255, 30, P_ONES, 8, 1, 32'hFFFFFFFF);
    add_row(K_GOOD, 1234, 5, 17, 3, 2, P_INC, 1, 1, 32'h00010000);
    add_row(K_GOOD, 85, 10, 42, 170, 6, P_RAND, 2, 0, 0);
    add_row(K_BAD_HCRC, 300, 1, 1, 1, 4, P_RAND, 0, 0, 0);
    add_row(K_BAD_PCRC, 700, 2, 2, 2, 8, P_RAND, 0, 0, 0);
    add_row(K_GOOD, 1024, 21, 31, 85, 12, P_INC, 3, 1, 32'h00010203);
    add_row(K_MISMATCH, 9, 3, 4, 4, 6, P_RAND, -1, 0, 0);
    add_row(K_BAD_LEN, 9, 3, 4, 4, 6, P_RAND, -1, 0, 0);
    add_row(K_NOISE, 0, 0, 0, 0, 0, P_RAND, -1, 0, 0);
    add_row(K_GOOD, 513, 17, 9, 128, 4, P_ONES, -1, 0, 0);

    write_offset(8'h00);
    foreach (rows[i]) begin
      n_prior = n_pushed;
      send_record(rows[i]);
      n = n_pushed - n_prior;
      if (rows[i].n_words >= 0 && n != rows[i].n_words) begin
        $display("%0t: record %0d gave %0d words, expected %0d", $time, i, n,
                 rows[i].n_words);
        errors++;
      end
      if (rows[i].w0_known && n > 0 && last_word0 !== rows[i].w0) begin
        $display("%0t: record %0d first word expected %0h, got %0h", $time, i,
                 rows[i].w0, last_word0);
        errors++;
      end
    end

    write_offset(8'hFF);
    hold_req = 1;
    n = n_sent + 20;
    while (n_sent < n) send_record(random_row());

    write_offset(8'($urandom_range(1, 254)));
    quiet = 1;
    n = n_sent + 20;
    while (n_sent < n) send_record(random_row());
    quiet = 0;

    write_offset(8'h80);
    n = n_sent + 20;
    while (n_sent < n) send_record(random_row());

    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
